>>> hw/rtl/bcgo_pkg.sv
`timescale 1ns / 1ps

package bcgo_pkg;

    // Fixed field widths of the chromosome word and its positions.
    localparam int WORD_W = 64;
    localparam int LEN_W  = 7;
    localparam int POS_W  = 6;
    localparam int IDX_W  = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_LENGTH    = 2'd0,
        REG_XOVER     = 2'd1,
        REG_MUTATION  = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_MUTATE    = 1'b0,
        OP_CROSSOVER = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        XO_SINGLE = 2'd0,
        XO_DOUBLE = 2'd1,
        XO_MASK   = 2'd2,
        XO_SPARE  = 2'd3
    } xover_mode_t;

    typedef enum logic {
        MUT_FLIP    = 1'b0,
        MUT_REVERSE = 1'b1
    } mut_mode_t;

    // Configuration as seen by the operator logic.
    typedef struct packed {
        logic [LEN_W-1:0] allele_count;
        logic [1:0]       crossover_mode;
        logic             mutation_mode;
    } cfg_t;

    // One input item as held in the input register.
    typedef struct packed {
        logic              opcode;
        logic [WORD_W-1:0] parent_a;
        logic [WORD_W-1:0] parent_b;
        logic [POS_W-1:0]  cut_first;
        logic [POS_W-1:0]  cut_second;
        logic [WORD_W-1:0] crossover_mask;
        logic              swap_parents;
        logic [POS_W-1:0]  flip_position;
    } item_t;

    // Word with the top n bits set, n from 0 to 64.
    function automatic logic [WORD_W-1:0] head_bits(input logic [LEN_W-1:0] n);
        logic [WORD_W-1:0] ones;
        ones = '1;
        return ~(ones >> n);
    endfunction

    // Full bit reversal of a word.
    function automatic logic [WORD_W-1:0] bit_rev(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] r;
        for (int i = 0; i < WORD_W; i++) begin
            r[i] = x[WORD_W-1-i];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/bcgo_cfg.sv
`timescale 1ns / 1ps

module bcgo_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bcgo_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bcgo_pkg::WORD_W-1:0]  cfg_data,
    output bcgo_pkg::cfg_t               cfg
);
    import bcgo_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Decode the register index; unknown indexes leave the registers alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_LENGTH:   cfg_next.allele_count   = cfg_data[LEN_W-1:0];
                REG_XOVER:    cfg_next.crossover_mode = cfg_data[1:0];
                REG_MUTATION: cfg_next.mutation_mode  = cfg_data[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.allele_count   <= LEN_RESET;
            cfg_reg.crossover_mode <= XO_SINGLE;
            cfg_reg.mutation_mode  <= MUT_FLIP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/bcgo_ops.sv
`timescale 1ns / 1ps

module bcgo_ops #(
    parameter int MAX_ALLELES = 64
) (
    input  bcgo_pkg::cfg_t               cfg,
    input  bcgo_pkg::item_t              item,
    output logic [bcgo_pkg::WORD_W-1:0]  child
);
    import bcgo_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ALLELES);

    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] valid_mask;
    logic [POS_W-1:0]  len_m1;
    logic [POS_W-1:0]  flip_p;
    logic [POS_W-1:0]  cut1_p;
    logic [POS_W-1:0]  cut2_p;
    logic [POS_W-1:0]  lo_p;
    logic [POS_W-1:0]  hi_p;
    logic [POS_W-1:0]  rev_shift;
    logic [WORD_W-1:0] x_word;
    logic [WORD_W-1:0] y_word;
    logic [WORD_W-1:0] mid_mask;
    logic [WORD_W-1:0] head_mask;
    logic [WORD_W-1:0] raw_child;

    // Effective length, clamped to 1..MAX_ALLELES.
    always_comb
    begin
        if (cfg.allele_count == '0) begin
            len = LEN_W'(1);
        end else if (cfg.allele_count > MAX_LEN) begin
            len = MAX_LEN;
        end else begin
            len = cfg.allele_count;
        end
    end

    assign valid_mask = head_bits(len);
    assign len_m1     = POS_W'(len - LEN_W'(1));
    assign rev_shift  = POS_W'(LEN_W'(WORD_W) - len);

    // Positions at or above the length saturate to the last allele.
    assign flip_p = ({1'b0, item.flip_position} >= len) ? len_m1 : item.flip_position;
    assign cut1_p = ({1'b0, item.cut_first}     >= len) ? len_m1 : item.cut_first;
    assign cut2_p = ({1'b0, item.cut_second}    >= len) ? len_m1 : item.cut_second;

    // Sorted cuts and parent roles for double cut.
    assign lo_p   = (cut1_p > cut2_p) ? cut2_p : cut1_p;
    assign hi_p   = (cut1_p > cut2_p) ? cut1_p : cut2_p;
    assign x_word = item.swap_parents ? item.parent_b : item.parent_a;
    assign y_word = item.swap_parents ? item.parent_a : item.parent_b;

    assign mid_mask  = head_bits({1'b0, hi_p}) & ~head_bits(LEN_W'({1'b0, lo_p}) + LEN_W'(1));
    assign head_mask = head_bits(LEN_W'({1'b0, cut1_p}) + LEN_W'(1));

    // Operator select.
    always_comb
    begin
        if (opcode_t'(item.opcode) == OP_MUTATE) begin
            if (mut_mode_t'(cfg.mutation_mode) == MUT_REVERSE) begin
                raw_child = bit_rev(item.parent_a & valid_mask) << rev_shift;
            end else begin
                raw_child = item.parent_a ^ ({1'b1, {(WORD_W-1){1'b0}}} >> flip_p);
            end
        end else begin
            case (xover_mode_t'(cfg.crossover_mode))
                XO_DOUBLE: raw_child = (x_word & ~mid_mask) | (y_word & mid_mask);
                XO_MASK:   raw_child = (item.parent_a & ~item.crossover_mask)
                                     | (item.parent_b & item.crossover_mask);
                default:   raw_child = (item.parent_a & head_mask)
                                     | (item.parent_b & ~head_mask);
            endcase
        end
    end

    // Padding alleles are always zero.
    assign child = raw_child & valid_mask;

endmodule

>>> hw/rtl/binary_chromosome_genetic_operators.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Beat
// in       input      in_valid / in_stall    opcode, parents, cuts, mask, swap, flip
// out      output     out_valid / out_stall  child
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An input beat is registered, the operator logic runs between the input register
// and the result register, and the child is then held in the result register.
// One beat is accepted per cycle while in_stall is low; the operator path is combinational.
// Reset clears both valid flags and loads the configuration defaults.
// A stalled result holds the result register and backs up into the input register;
// in_stall rises only when both registers are full.

module binary_chromosome_genetic_operators #(
    parameter int MAX_ALLELES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         opcode,
    input  logic [bcgo_pkg::WORD_W-1:0]  parent_a,
    input  logic [bcgo_pkg::WORD_W-1:0]  parent_b,
    input  logic [bcgo_pkg::POS_W-1:0]   cut_first,
    input  logic [bcgo_pkg::POS_W-1:0]   cut_second,
    input  logic [bcgo_pkg::WORD_W-1:0]  crossover_mask,
    input  logic                         swap_parents,
    input  logic [bcgo_pkg::POS_W-1:0]   flip_position,
    // Output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bcgo_pkg::WORD_W-1:0]  child,
    // Configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bcgo_pkg::IDX_W-1:0]   cfg_index,
    input  logic [bcgo_pkg::WORD_W-1:0]  cfg_data
);
    import bcgo_pkg::*;

    cfg_t              cfg;
    item_t             item_reg;
    logic              item_valid_reg;
    logic [WORD_W-1:0] child_next;
    logic [WORD_W-1:0] child_reg;
    logic              out_valid_reg;
    logic              out_load;
    logic              in_load;

    bcgo_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcgo_ops #(
        .MAX_ALLELES (MAX_ALLELES)
    ) u_ops (
        .cfg   (cfg),
        .item  (item_reg),
        .child (child_next)
    );

    // Pipeline advance: the result register loads when empty or drained,
    // the input register loads when its content moves on or it is empty.
    assign out_load = !out_valid_reg || !out_stall;
    assign in_stall = item_valid_reg && !out_load;
    assign in_load  = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load) begin
            item_reg.opcode         <= opcode;
            item_reg.parent_a       <= parent_a;
            item_reg.parent_b       <= parent_b;
            item_reg.cut_first      <= cut_first;
            item_reg.cut_second     <= cut_second;
            item_reg.crossover_mask <= crossover_mask;
            item_reg.swap_parents   <= swap_parents;
            item_reg.flip_position  <= flip_position;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && item_valid_reg) begin
            child_reg <= child_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign child     = child_reg;

endmodule

>>> tb/binary_chromosome_genetic_operators_tb.sv
`timescale 1ns / 1ps

module binary_chromosome_genetic_operators_tb;

    import bcgo_pkg::*;

    localparam int MAX_ALLELES = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 4;
    localparam int PHASE_ITEMS = 100;
    localparam int PHASE_COUNT = 14;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    item_t             cur_item;
    logic              out_valid;
    logic              out_stall;
    logic [WORD_W-1:0] child;
    logic              cfg_valid;
    logic              cfg_ready;
    reg_idx_t          cfg_index;
    logic [WORD_W-1:0] cfg_data;

    // Local copy of the configuration registers.
    logic [LEN_W-1:0]  cfg_length;
    xover_mode_t       cfg_xover;
    mut_mode_t         cfg_mut;

    // Children predicted for accepted beats, oldest first.
    logic [WORD_W-1:0] pending_children[$];
    int                child_errors;
    int                cycle_count;

    // Idling controls shared between the stimulus and the receiver.
    bit                sender_idle_en;
    bit                stall_en;
    int unsigned       hold_cycles;

    binary_chromosome_genetic_operators #(
        .MAX_ALLELES(MAX_ALLELES)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (cur_item.opcode),
        .parent_a       (cur_item.parent_a),
        .parent_b       (cur_item.parent_b),
        .cut_first      (cur_item.cut_first),
        .cut_second     (cur_item.cut_second),
        .crossover_mask (cur_item.crossover_mask),
        .swap_parents   (cur_item.swap_parents),
        .flip_position  (cur_item.flip_position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .child          (child),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle limit in case the block hangs.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("binary_chromosome_genetic_operators: mismatch");
        $finish;
    end

    // Effective number of valid alleles after the length limits are applied.
    function automatic int unsigned eff_len();
        int unsigned n;
        n = 32'(cfg_length);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > MAX_ALLELES)
        begin
            n = MAX_ALLELES;
        end
        return n;
    endfunction

    // Word with the top n bits set.
    function automatic logic [WORD_W-1:0] leading_ones(input int unsigned n);
        if (n == 0)
        begin
            return '0;
        end
        if (n >= WORD_W)
        begin
            return '1;
        end
        return ~64'd0 << (WORD_W - n);
    endfunction

    // Positions at or beyond the length fall back to the last allele.
    function automatic int unsigned clamp_pos(input logic [POS_W-1:0] raw,
                                              input int unsigned len);
        return (32'(raw) >= len) ? len - 1 : 32'(raw);
    endfunction

    // Child word that the block must return for one beat.
    function automatic logic [WORD_W-1:0] predict_child(input item_t it);
        int unsigned       len;
        int unsigned       p1;
        int unsigned       p2;
        int unsigned       tmp;
        int                k;
        logic [WORD_W-1:0] keep;
        logic [WORD_W-1:0] flat;
        logic [WORD_W-1:0] outer_src;
        logic [WORD_W-1:0] inner_src;
        logic [WORD_W-1:0] middle;
        logic [WORD_W-1:0] head;
        logic [WORD_W-1:0] result;
        len  = eff_len();
        keep = leading_ones(len);
        if (it.opcode == OP_MUTATE)
        begin
            if (cfg_mut == MUT_REVERSE)
            begin
                // Mirror the whole word, then move the reversed alleles back to the top.
                flat = it.parent_a & keep;
                for (k = 0; k < WORD_W; k++)
                begin
                    result[k] = flat[WORD_W-1-k];
                end
                result = result << (WORD_W - len);
            end
            else
            begin
                result = it.parent_a ^ (64'd1 << (63 - clamp_pos(it.flip_position, len)));
            end
        end
        else
        begin
            case (cfg_xover)
                XO_DOUBLE:
                begin
                    // Sorted cuts; the alleles strictly between them come from the other parent.
                    p1 = clamp_pos(it.cut_first, len);
                    p2 = clamp_pos(it.cut_second, len);
                    if (p1 > p2)
                    begin
                        tmp = p1;
                        p1  = p2;
                        p2  = tmp;
                    end
                    outer_src = it.swap_parents ? it.parent_b : it.parent_a;
                    inner_src = it.swap_parents ? it.parent_a : it.parent_b;
                    middle    = leading_ones(p2) & ~leading_ones(p1 + 1);
                    result    = (outer_src & ~middle) | (inner_src & middle);
                end
                XO_MASK:
                begin
                    result = (it.parent_a & ~it.crossover_mask)
                           | (it.parent_b & it.crossover_mask);
                end
                default:
                begin
                    // Single cut; the spare mode behaves the same way.
                    head   = leading_ones(clamp_pos(it.cut_first, len) + 1);
                    result = (it.parent_a & head) | (it.parent_b & ~head);
                end
            endcase
        end
        return result & keep;
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Half of the positions fall inside the chromosome, the rest anywhere.
    function automatic logic [POS_W-1:0] random_pos(input int unsigned len);
        if ($urandom_range(0, 1) == 1)
        begin
            return POS_W'($urandom_range(0, 63));
        end
        return POS_W'($urandom_range(0, len - 1));
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned len;
        len               = eff_len();
        it.opcode         = opcode_t'($urandom_range(0, 1));
        it.parent_a       = random_word();
        it.parent_b       = random_word();
        it.cut_first      = random_pos(len);
        it.cut_second     = random_pos(len);
        it.crossover_mask = random_word();
        it.swap_parents   = 1'($urandom_range(0, 1));
        it.flip_position  = random_pos(len);
        return it;
    endfunction

    // Offer one beat, after a random gap when idling is enabled, and record its child once taken.
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = sender_idle_en ? $urandom_range(0, 16) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cur_item <= it;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pending_children.push_back(predict_child(it));
    endtask

    // Stop offering beats and wait until every predicted child has arrived.
    task automatic wait_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_children.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // One register write; the local copy follows the write.
    task automatic write_reg(input reg_idx_t idx, input logic [WORD_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            REG_LENGTH:   cfg_length = data[LEN_W-1:0];
            REG_XOVER:    cfg_xover  = xover_mode_t'(data[1:0]);
            REG_MUTATION: cfg_mut    = mut_mode_t'(data[0]);
            default:      ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain, then write all three registers; the upper data bits carry noise.
    task automatic set_config(input logic [LEN_W-1:0] len, input xover_mode_t xo,
                              input mut_mode_t mut);
        logic [WORD_W-1:0] noise;
        wait_results();
        noise = {$urandom, $urandom};
        write_reg(REG_LENGTH, {noise[WORD_W-1:LEN_W], len});
        write_reg(REG_XOVER, {noise[WORD_W-1:2], 2'(xo)});
        write_reg(REG_MUTATION, {noise[WORD_W-1:1], 1'(mut)});
    endtask

    // Reset values: full length, single cut, flip.
    task automatic test_reset_defaults();
        item_t it;
        it = random_item();
        it.opcode = OP_MUTATE;
        it.parent_a = '1;
        it.flip_position = 6'd0;
        send_item(it);
        it = random_item();
        it.opcode = OP_MUTATE;
        it.parent_a = '0;
        it.flip_position = 6'd63;
        send_item(it);
        it = random_item();
        it.opcode = OP_CROSSOVER;
        it.parent_a = '1;
        it.parent_b = '0;
        it.cut_first = 6'd63;
        send_item(it);
        it = random_item();
        it.opcode = OP_CROSSOVER;
        it.parent_a = '0;
        it.parent_b = '1;
        it.cut_first = 6'd0;
        send_item(it);
    endtask

    // Length zero acts as one allele, lengths past the maximum act as the maximum.
    task automatic test_length_extremes();
        item_t it;
        set_config(7'd0, XO_DOUBLE, MUT_REVERSE);
        it = random_item();
        it.opcode = OP_MUTATE;
        it.parent_a = '1;
        send_item(it);
        it = random_item();
        it.opcode = OP_CROSSOVER;
        it.cut_first = 6'd63;
        it.cut_second = 6'd0;
        send_item(it);
        set_config(7'd127, XO_DOUBLE, MUT_REVERSE);
        it = random_item();
        it.opcode = OP_MUTATE;
        send_item(it);
        it = random_item();
        it.opcode = OP_CROSSOVER;
        it.parent_a = '1;
        it.parent_b = '0;
        it.cut_first = 6'd10;
        it.cut_second = 6'd40;
        it.swap_parents = 1'b0;
        send_item(it);
        it.cut_first = 6'd40;
        it.cut_second = 6'd10;
        it.swap_parents = 1'b1;
        send_item(it);
        it.cut_first = 6'd20;
        it.cut_second = 6'd20;
        send_item(it);
    endtask

    // Mask crossover with full and empty masks, and the spare mode.
    task automatic test_crossover_modes();
        item_t it;
        set_config(7'd64, XO_MASK, MUT_FLIP);
        it = random_item();
        it.opcode = OP_CROSSOVER;
        send_item(it);
        it.crossover_mask = '1;
        send_item(it);
        it.crossover_mask = '0;
        send_item(it);
        set_config(7'd64, XO_SPARE, MUT_FLIP);
        it = random_item();
        it.opcode = OP_CROSSOVER;
        it.cut_first = 6'd5;
        send_item(it);
    endtask

    // Short chromosome: padding stays zero and positions saturate.
    task automatic test_short_chromosome();
        item_t it;
        set_config(7'd13, XO_SINGLE, MUT_FLIP);
        it = random_item();
        it.opcode = OP_MUTATE;
        it.parent_a = '1;
        it.flip_position = 6'd50;
        send_item(it);
        it.flip_position = 6'd12;
        send_item(it);
        it = random_item();
        it.opcode = OP_CROSSOVER;
        it.parent_a = '1;
        it.parent_b = '1;
        it.cut_first = 6'd13;
        send_item(it);
        set_config(7'd13, XO_SINGLE, MUT_REVERSE);
        it = random_item();
        it.opcode = OP_MUTATE;
        send_item(it);
        // A write to the spare index must leave the configuration alone.
        wait_results();
        write_reg(REG_UNUSED, {$urandom, $urandom});
        it = random_item();
        send_item(it);
    endtask

    // The receiver holds off for a long stretch while beats keep coming.
    task automatic test_backpressure();
        set_config(7'd64, XO_DOUBLE, MUT_FLIP);
        sender_idle_en = 1'b0;
        hold_cycles = 60;
        repeat (30) send_item(random_item());
        wait_results();
    endtask

    // Random beats across a sweep of settings, with and without idling.
    task automatic test_random_phases();
        logic [LEN_W-1:0] lengths[10];
        logic [LEN_W-1:0] len;
        int               ph;
        lengths = '{7'd0, 7'd1, 7'd2, 7'd8, 7'd13, 7'd32, 7'd63, 7'd64, 7'd65, 7'd127};
        for (ph = 0; ph < PHASE_COUNT; ph++)
        begin
            len = (ph < 10) ? lengths[ph] : LEN_W'($urandom_range(0, 127));
            set_config(len, xover_mode_t'(ph % 4), mut_mode_t'(((ph / 4) + ph) % 2));
            sender_idle_en = (ph % 3) != 0;
            stall_en = (ph % 4) != 1;
            repeat (PHASE_ITEMS) send_item(random_item());
        end
    endtask

    // Receiver: random stall per beat, plus long holds on request.
    initial
    begin
        int unsigned gap;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = stall_en ? $urandom_range(0, 16) : 0;
            gap = gap + hold_cycles;
            hold_cycles = 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid && hold_cycles == 0);
        end
    end

    // Compare every accepted child with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_children.size() == 0)
            begin
                $error("child: expected none, actual %h", child);
                child_errors++;
            end
            else if (child !== pending_children[0])
            begin
                $error("child: expected %h, actual %h", pending_children[0], child);
                child_errors++;
                void'(pending_children.pop_front());
            end
            else
            begin
                void'(pending_children.pop_front());
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cur_item = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_LENGTH;
        cfg_data = '0;
        cfg_length = LEN_RESET;
        cfg_xover = XO_SINGLE;
        cfg_mut = MUT_FLIP;
        child_errors = 0;
        sender_idle_en = 1'b1;
        stall_en = 1'b1;
        hold_cycles = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_length_extremes();
        test_crossover_modes();
        test_short_chromosome();
        test_backpressure();
        test_random_phases();
        wait_results();

        if (child_errors == 0)
        begin
            $display("binary_chromosome_genetic_operators: match");
        end
        else
        begin
            $display("binary_chromosome_genetic_operators: mismatch");
        end
        $finish;
    end

endmodule

>>> binary_chromosome_genetic_operators.f
hw/rtl/bcgo_pkg.sv
hw/rtl/bcgo_cfg.sv
hw/rtl/bcgo_ops.sv
hw/rtl/binary_chromosome_genetic_operators.sv
tb/binary_chromosome_genetic_operators_tb.sv
